// File: rtl/core/pdmp_pkg.sv
// shared types and constants for the pluq decomposition block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pdmp_pkg;

  // width of the modulus and of every reduced field value
  localparam int unsigned MOD_BITS = 16;
  // product bits retired per cycle by the modular reduction
  localparam int unsigned SLICE = 4;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  // unused code, answered like a write that stores nothing
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic [1:0] CFG_MODULUS  = 2'd0;
  localparam logic [1:0] CFG_NUM_ROWS = 2'd1;
  localparam logic [1:0] CFG_NUM_COLS = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_INIT,
    ST_TOP,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_ROT_RD0,
    ST_ROT_T,
    ST_ROT_RD,
    ST_ROT_WR,
    ST_SWP_RA,
    ST_SWP_RB,
    ST_SWP_WA,
    ST_SWP_WB,
    ST_INV_RD,
    ST_INV_LD,
    ST_INV_BW,
    ST_INV_LOOP,
    ST_INV_AW,
    ST_INV_SQ,
    ST_INV_SW,
    ST_EL_TOP,
    ST_EL_ML,
    ST_EL_MW,
    ST_EL_J,
    ST_EL_P,
    ST_EL_PW,
    ST_EL_A,
    ST_EL_AW
  } state_e;

endpackage
`default_nettype wire

// File: rtl/core/pdmp_modmul.sv
// multi-cycle modular multiplier: registered product, then slice-wise restoring reduction
// depends on pdmp_pkg
`timescale 1ns / 1ps
`default_nettype none
module pdmp_modmul #(
  parameter int unsigned OW = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [OW-1:0]                a_i,
  input  wire logic [OW-1:0]                b_i,
  input  wire logic [pdmp_pkg::MOD_BITS-1:0] p_i,
  output logic                              done_o,
  output logic [pdmp_pkg::MOD_BITS-1:0]     res_o
);

  localparam int unsigned PW    = 2 * OW;
  localparam int unsigned NSTEP = (PW + pdmp_pkg::SLICE - 1) / pdmp_pkg::SLICE;
  localparam int unsigned PPW   = NSTEP * pdmp_pkg::SLICE;
  localparam int unsigned SW    = $clog2(NSTEP);
  localparam int unsigned RMW   = pdmp_pkg::MOD_BITS + 1;

  logic [PPW-1:0] prod_q;
  logic [RMW-1:0] rem_q, rem_d;
  logic [SW-1:0]  cnt_q;
  logic           run_q, done_q;
  logic [PW-1:0]  prod_w;

  assign prod_w = PW'(a_i) * PW'(b_i);

  // one restoring step per product bit, msb first
  always_comb begin
    logic [RMW-1:0] t;
    t = rem_q;
    for (int b = 0; b < int'(pdmp_pkg::SLICE); b++) begin
      t = {t[RMW-2:0], prod_q[PPW-1-b]};
      if (t >= {1'b0, p_i}) begin
        t = t - {1'b0, p_i};
      end
    end
    rem_d = t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + SW'(1);
        if (cnt_q == SW'(NSTEP - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PPW'(prod_w);
      rem_q  <= '0;
    end else if (run_q) begin
      prod_q <= prod_q << pdmp_pkg::SLICE;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = rem_q[pdmp_pkg::MOD_BITS-1:0];

endmodule
`default_nettype wire

// File: rtl/core/pluq_decompose_mod_prime.sv
// top level of the pluq decomposition over a prime field
// depends on pdmp_pkg and pdmp_modmul
//
// The block keeps a MAX_DIM x MAX_DIM element store in one synchronous memory and
// works on one command at a time. An item is taken when start_i is high and busy_o
// is low; every item gives exactly one result beat, shown for one cycle with done_o
// high, and the receiver cannot hold it off. The beat of an element write follows in
// the next cycle; a read's beat comes after the registered read data and the READ
// state. A decomposition run is driven by a sequencer around one shared modular
// multiplier: each elimination update needs two multiply-mods plus two memory
// reads, and the pivot inverse up to about 32 multiplies. Column swaps and row
// rotations go element by element. rank_found_o always shows the rank of the last
// run. Configuration writes are taken only while no command is in progress.
`timescale 1ns / 1ps
`default_nettype none
module pluq_decompose_mod_prime #(
  parameter int unsigned MAX_DIM   = 16,
  parameter int unsigned ELEM_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [3:0]  row_i,
  input  wire logic [3:0]  col_i,
  input  wire logic [15:0] value_i,
  output logic             done_o,
  output logic [15:0]      element_o,
  output logic [4:0]       rank_found_o,
  output logic [3:0]       row_perm_entry_o,
  output logic [3:0]       col_perm_entry_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned MB  = pdmp_pkg::MOD_BITS;
  localparam int unsigned OW  = (ELEM_BITS > MB) ? ELEM_BITS : MB;
  localparam int unsigned AW  = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned RW  = $clog2(MAX_DIM);
  localparam int unsigned CW  = $clog2(MAX_DIM + 1);

  pdmp_pkg::state_e state_q, state_d;

  // configuration registers
  logic [15:0] modulus_q;
  logic [4:0]  nrows_q, ncols_q;

  // element store, read data registered
  logic [ELEM_BITS-1:0] mem_q [MAX_DIM*MAX_DIM];
  logic [ELEM_BITS-1:0] rdata_q;
  logic [AW-1:0]        raddr, waddr;
  logic [ELEM_BITS-1:0] wdata;
  logic                 we;

  logic [RW-1:0] rp_q [MAX_DIM];
  logic [RW-1:0] cp_q [MAX_DIM];
  logic [CW-1:0] rank_q;

  // sequencer counters and scratch
  logic [CW-1:0] r_q, nul_q, piv_q, i_q, j_q, k_q;
  logic [ELEM_BITS-1:0] tmp_q;
  logic [MB-1:0] base_q, acc_q, inv_q, mlt_q, prod_q, e_q;

  // result beat
  logic        done_q;
  logic [15:0] element_q;
  logic [3:0]  rpe_q, cpe_q;

  // multiplier
  logic          mm_start, mm_done;
  logic [OW-1:0] mm_a, mm_b;
  logic [MB-1:0] mm_res;

  logic [MB-1:0] p_eff;
  logic [CW-1:0] m_eff, n_eff;
  logic          in_range;
  logic [CW:0]   rn_sum;
  logic [MB:0]   sub_raw;
  logic [MB-1:0] sub_val;

  function automatic logic [AW-1:0] addr_f(input logic [CW-1:0] rr, input logic [CW-1:0] cc);
    return AW'(rr) * AW'(MAX_DIM) + AW'(cc);
  endfunction

  assign p_eff    = (modulus_q < 16'd2) ? MB'(2) : MB'(modulus_q);
  assign m_eff    = (nrows_q == 5'd0) ? CW'(1) :
                    (32'(nrows_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(nrows_q);
  assign n_eff    = (ncols_q == 5'd0) ? CW'(1) :
                    (32'(ncols_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(ncols_q);
  assign in_range = (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
  assign rn_sum   = {1'b0, r_q} + {1'b0, nul_q};

  // trailing update: (a mod p) - prod, back into range
  assign sub_raw = {1'b0, mm_res} + {1'b0, p_eff} - {1'b0, prod_q};
  assign sub_val = (sub_raw >= {1'b0, p_eff}) ? MB'(sub_raw - {1'b0, p_eff}) : MB'(sub_raw);

  pdmp_modmul #(
    .OW(OW)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .p_i    (p_eff),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // sequencer: next state, memory port and multiplier control
  always_comb begin
    state_d  = state_q;
    raddr    = '0;
    waddr    = '0;
    wdata    = '0;
    we       = 1'b0;
    mm_start = 1'b0;
    mm_a     = '0;
    mm_b     = '0;
    unique case (state_q)
      pdmp_pkg::ST_IDLE: begin
        if (start_i) begin
          if (func_i == pdmp_pkg::FUNC_WRITE && in_range) begin
            we    = 1'b1;
            waddr = addr_f(CW'(row_i), CW'(col_i));
            wdata = ELEM_BITS'(value_i);
          end else if (func_i == pdmp_pkg::FUNC_RUN) begin
            state_d = pdmp_pkg::ST_INIT;
          end else if (func_i == pdmp_pkg::FUNC_READ && in_range) begin
            raddr   = addr_f(CW'(row_i), CW'(col_i));
            state_d = pdmp_pkg::ST_READ;
          end
        end
      end
      pdmp_pkg::ST_READ: state_d = pdmp_pkg::ST_IDLE;
      pdmp_pkg::ST_INIT: state_d = pdmp_pkg::ST_TOP;
      pdmp_pkg::ST_TOP: begin
        if (rn_sum >= {1'b0, m_eff}) state_d = pdmp_pkg::ST_IDLE;
        else state_d = pdmp_pkg::ST_SCAN;
      end
      pdmp_pkg::ST_SCAN: begin
        if (piv_q >= n_eff) begin
          state_d = pdmp_pkg::ST_ROT_RD0;
        end else begin
          raddr   = addr_f(r_q, piv_q);
          state_d = pdmp_pkg::ST_SCAN_CHK;
        end
      end
      pdmp_pkg::ST_SCAN_CHK: begin
        if (rdata_q == '0) state_d = pdmp_pkg::ST_SCAN;
        else if (piv_q != r_q) state_d = pdmp_pkg::ST_SWP_RA;
        else state_d = pdmp_pkg::ST_INV_RD;
      end
      pdmp_pkg::ST_ROT_RD0: begin
        raddr   = addr_f(r_q, j_q);
        state_d = pdmp_pkg::ST_ROT_T;
      end
      pdmp_pkg::ST_ROT_T: state_d = pdmp_pkg::ST_ROT_RD;
      pdmp_pkg::ST_ROT_RD: begin
        if ({1'b0, i_q} + 1'b1 < {1'b0, m_eff}) begin
          raddr   = addr_f(i_q + CW'(1), j_q);
          state_d = pdmp_pkg::ST_ROT_WR;
        end else begin
          we    = 1'b1;
          waddr = addr_f(i_q, j_q);
          wdata = tmp_q;
          if (j_q == CW'(MAX_DIM - 1)) state_d = pdmp_pkg::ST_TOP;
          else state_d = pdmp_pkg::ST_ROT_RD0;
        end
      end
      pdmp_pkg::ST_ROT_WR: begin
        we      = 1'b1;
        waddr   = addr_f(i_q, j_q);
        wdata   = rdata_q;
        state_d = pdmp_pkg::ST_ROT_RD;
      end
      pdmp_pkg::ST_SWP_RA: begin
        raddr   = addr_f(i_q, r_q);
        state_d = pdmp_pkg::ST_SWP_RB;
      end
      pdmp_pkg::ST_SWP_RB: begin
        raddr   = addr_f(i_q, piv_q);
        state_d = pdmp_pkg::ST_SWP_WA;
      end
      pdmp_pkg::ST_SWP_WA: begin
        we      = 1'b1;
        waddr   = addr_f(i_q, r_q);
        wdata   = rdata_q;
        state_d = pdmp_pkg::ST_SWP_WB;
      end
      pdmp_pkg::ST_SWP_WB: begin
        we    = 1'b1;
        waddr = addr_f(i_q, piv_q);
        wdata = tmp_q;
        if (i_q == m_eff - CW'(1)) state_d = pdmp_pkg::ST_INV_RD;
        else state_d = pdmp_pkg::ST_SWP_RA;
      end
      pdmp_pkg::ST_INV_RD: begin
        raddr   = addr_f(r_q, r_q);
        state_d = pdmp_pkg::ST_INV_LD;
      end
      pdmp_pkg::ST_INV_LD: begin
        mm_start = 1'b1;
        mm_a     = OW'(rdata_q);
        mm_b     = OW'(1);
        state_d  = pdmp_pkg::ST_INV_BW;
      end
      pdmp_pkg::ST_INV_BW: if (mm_done) state_d = pdmp_pkg::ST_INV_LOOP;
      pdmp_pkg::ST_INV_LOOP: begin
        if (e_q == '0) begin
          state_d = pdmp_pkg::ST_EL_TOP;
        end else if (e_q[0]) begin
          mm_start = 1'b1;
          mm_a     = OW'(acc_q);
          mm_b     = OW'(base_q);
          state_d  = pdmp_pkg::ST_INV_AW;
        end else begin
          state_d = pdmp_pkg::ST_INV_SQ;
        end
      end
      pdmp_pkg::ST_INV_AW: if (mm_done) state_d = pdmp_pkg::ST_INV_SQ;
      pdmp_pkg::ST_INV_SQ: begin
        mm_start = 1'b1;
        mm_a     = OW'(base_q);
        mm_b     = OW'(base_q);
        state_d  = pdmp_pkg::ST_INV_SW;
      end
      pdmp_pkg::ST_INV_SW: if (mm_done) state_d = pdmp_pkg::ST_INV_LOOP;
      pdmp_pkg::ST_EL_TOP: begin
        if (k_q >= m_eff) begin
          state_d = pdmp_pkg::ST_TOP;
        end else begin
          raddr   = addr_f(k_q, r_q);
          state_d = pdmp_pkg::ST_EL_ML;
        end
      end
      pdmp_pkg::ST_EL_ML: begin
        mm_start = 1'b1;
        mm_a     = OW'(rdata_q);
        mm_b     = OW'(inv_q);
        state_d  = pdmp_pkg::ST_EL_MW;
      end
      pdmp_pkg::ST_EL_MW: begin
        if (mm_done) begin
          we      = 1'b1;
          waddr   = addr_f(k_q, r_q);
          wdata   = ELEM_BITS'(mm_res);
          state_d = pdmp_pkg::ST_EL_J;
        end
      end
      pdmp_pkg::ST_EL_J: begin
        if (j_q >= n_eff) begin
          state_d = pdmp_pkg::ST_EL_TOP;
        end else begin
          raddr   = addr_f(r_q, j_q);
          state_d = pdmp_pkg::ST_EL_P;
        end
      end
      pdmp_pkg::ST_EL_P: begin
        mm_start = 1'b1;
        mm_a     = OW'(mlt_q);
        mm_b     = OW'(rdata_q);
        state_d  = pdmp_pkg::ST_EL_PW;
      end
      pdmp_pkg::ST_EL_PW: begin
        if (mm_done) begin
          raddr   = addr_f(k_q, j_q);
          state_d = pdmp_pkg::ST_EL_A;
        end
      end
      pdmp_pkg::ST_EL_A: begin
        // reduce the raw target element before subtracting
        mm_start = 1'b1;
        mm_a     = OW'(rdata_q);
        mm_b     = OW'(1);
        state_d  = pdmp_pkg::ST_EL_AW;
      end
      pdmp_pkg::ST_EL_AW: begin
        if (mm_done) begin
          we      = 1'b1;
          waddr   = addr_f(k_q, j_q);
          wdata   = ELEM_BITS'(sub_val);
          state_d = pdmp_pkg::ST_EL_J;
        end
      end
      default: state_d = pdmp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pdmp_pkg::ST_IDLE;
      done_q    <= 1'b0;
      modulus_q <= 16'd65521;
      nrows_q   <= 5'd16;
      ncols_q   <= 5'd16;
      rank_q    <= '0;
      element_q <= '0;
      rpe_q     <= '0;
      cpe_q     <= '0;
      r_q       <= '0;
      nul_q     <= '0;
      piv_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      tmp_q     <= '0;
      base_q    <= '0;
      acc_q     <= '0;
      inv_q     <= '0;
      mlt_q     <= '0;
      prod_q    <= '0;
      e_q       <= '0;
      for (int x = 0; x < int'(MAX_DIM); x++) begin
        rp_q[x] <= RW'(x);
        cp_q[x] <= RW'(x);
      end
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pdmp_pkg::CFG_MODULUS:  modulus_q <= cfg_data_i;
          pdmp_pkg::CFG_NUM_ROWS: nrows_q   <= cfg_data_i[4:0];
          pdmp_pkg::CFG_NUM_COLS: ncols_q   <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      case (state_q)
        pdmp_pkg::ST_IDLE: begin
          if (start_i) begin
            element_q <= '0;
            if (func_i == pdmp_pkg::FUNC_READ && in_range) begin
              rpe_q <= 4'(rp_q[RW'(row_i)]);
              cpe_q <= 4'(cp_q[RW'(col_i)]);
            end else begin
              rpe_q <= '0;
              cpe_q <= '0;
              if (func_i != pdmp_pkg::FUNC_RUN) done_q <= 1'b1;
            end
          end
        end
        pdmp_pkg::ST_READ: begin
          element_q <= 16'(rdata_q);
          done_q    <= 1'b1;
        end
        pdmp_pkg::ST_INIT: begin
          for (int x = 0; x < int'(MAX_DIM); x++) begin
            rp_q[x] <= RW'(x);
            cp_q[x] <= RW'(x);
          end
          r_q   <= '0;
          nul_q <= '0;
        end
        pdmp_pkg::ST_TOP: begin
          if (rn_sum >= {1'b0, m_eff}) begin
            rank_q <= r_q;
            done_q <= 1'b1;
          end
          piv_q <= r_q;
        end
        pdmp_pkg::ST_SCAN: j_q <= '0;
        pdmp_pkg::ST_SCAN_CHK: begin
          if (rdata_q == '0) piv_q <= piv_q + CW'(1);
          i_q <= '0;
        end
        pdmp_pkg::ST_ROT_RD0: i_q <= r_q;
        pdmp_pkg::ST_ROT_T: tmp_q <= rdata_q;
        pdmp_pkg::ST_ROT_RD: begin
          if (!({1'b0, i_q} + 1'b1 < {1'b0, m_eff})) begin
            j_q <= j_q + CW'(1);
            if (j_q == CW'(MAX_DIM - 1)) begin
              // row moves to the bottom, rows below move up
              nul_q <= nul_q + CW'(1);
              for (int x = 0; x < int'(MAX_DIM); x++) begin
                if (CW'(x) >= r_q && 32'(x) + 1 < 32'(m_eff)) begin
                  rp_q[x] <= rp_q[(x + 1) % MAX_DIM];
                end
                if (32'(x) + 1 == 32'(m_eff)) begin
                  rp_q[x] <= rp_q[RW'(r_q)];
                end
              end
            end
          end
        end
        pdmp_pkg::ST_ROT_WR: i_q <= i_q + CW'(1);
        pdmp_pkg::ST_SWP_RB: tmp_q <= rdata_q;
        pdmp_pkg::ST_SWP_WB: begin
          if (i_q == m_eff - CW'(1)) begin
            cp_q[RW'(r_q)]   <= cp_q[RW'(piv_q)];
            cp_q[RW'(piv_q)] <= cp_q[RW'(r_q)];
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        pdmp_pkg::ST_INV_BW: begin
          if (mm_done) begin
            base_q <= mm_res;
            acc_q  <= MB'(1);
            e_q    <= p_eff - MB'(2);
          end
        end
        pdmp_pkg::ST_INV_LOOP: begin
          if (e_q == '0) begin
            inv_q <= acc_q;
            k_q   <= r_q + CW'(1);
          end
        end
        pdmp_pkg::ST_INV_AW: if (mm_done) acc_q <= mm_res;
        pdmp_pkg::ST_INV_SW: begin
          if (mm_done) begin
            base_q <= mm_res;
            e_q    <= e_q >> 1;
          end
        end
        pdmp_pkg::ST_EL_TOP: if (k_q >= m_eff) r_q <= r_q + CW'(1);
        pdmp_pkg::ST_EL_MW: begin
          if (mm_done) begin
            mlt_q <= MB'(ELEM_BITS'(mm_res));
            j_q   <= r_q + CW'(1);
          end
        end
        pdmp_pkg::ST_EL_J: if (j_q >= n_eff) k_q <= k_q + CW'(1);
        pdmp_pkg::ST_EL_PW: if (mm_done) prod_q <= mm_res;
        pdmp_pkg::ST_EL_AW: if (mm_done) j_q <= j_q + CW'(1);
        default: ;
      endcase
    end
  end

  assign busy_o           = (state_q != pdmp_pkg::ST_IDLE);
  // settings change only between commands
  assign cfg_ready_o      = (state_q == pdmp_pkg::ST_IDLE);
  assign done_o           = done_q;
  assign element_o        = element_q;
  assign rank_found_o     = 5'(rank_q);
  assign row_perm_entry_o = rpe_q;
  assign col_perm_entry_o = cpe_q;

endmodule
`default_nettype wire
